@@ src/hkve_pkg.sv @@
// Shared types, constants and the key table for the HID key to escape-sequence encoder.
// No dependencies; every other file in src imports this package.
package hkve_pkg;

  // Usage range covered by the key table
  localparam logic [7:0] KEY_FIRST = 8'h3A;
  localparam logic [7:0] KEY_LAST  = 8'h52;

  // ASCII characters used in the sequences
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;

  // Sequence storage: up to eight byte slots, count 0..8
  localparam int SEQ_SLOTS = 8;
  localparam int SLOT_W    = $clog2(SEQ_SLOTS);
  localparam int LEN_W     = SLOT_W + 1;

  // One key table entry: intro is 0 for the VT220 form
  typedef struct packed {
    logic [7:0] intro;
    logic [7:0] code;
  } key_entry_t;

  // One encoded sequence, as queued between front and back
  typedef struct packed {
    logic [SEQ_SLOTS-1:0][7:0] bytes;
    logic [LEN_W-1:0]          len;
  } seq_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Key table, indexed by usage - KEY_FIRST
  function automatic key_entry_t key_lookup(input logic [4:0] idx);
    key_entry_t e;
    unique case (idx)
      5'd0:    e = '{intro: 8'h4F, code: 8'h50};  // F1  O P
      5'd1:    e = '{intro: 8'h4F, code: 8'h51};  // F2  O Q
      5'd2:    e = '{intro: 8'h4F, code: 8'h52};  // F3  O R
      5'd3:    e = '{intro: 8'h4F, code: 8'h53};  // F4  O S
      5'd4:    e = '{intro: 8'h00, code: 8'd15};
      5'd5:    e = '{intro: 8'h00, code: 8'd17};
      5'd6:    e = '{intro: 8'h00, code: 8'd18};
      5'd7:    e = '{intro: 8'h00, code: 8'd19};
      5'd8:    e = '{intro: 8'h00, code: 8'd20};
      5'd9:    e = '{intro: 8'h00, code: 8'd21};
      5'd10:   e = '{intro: 8'h00, code: 8'd23};
      5'd11:   e = '{intro: 8'h00, code: 8'd24};
      5'd15:   e = '{intro: 8'h00, code: 8'd2};   // Insert
      5'd16:   e = '{intro: 8'h5B, code: 8'h48};  // Home
      5'd17:   e = '{intro: 8'h00, code: 8'd5};   // PageUp
      5'd18:   e = '{intro: 8'h00, code: 8'd3};   // Delete
      5'd19:   e = '{intro: 8'h5B, code: 8'h46};  // End
      5'd20:   e = '{intro: 8'h00, code: 8'd6};   // PageDown
      5'd21:   e = '{intro: 8'h5B, code: 8'h43};  // Right
      5'd22:   e = '{intro: 8'h5B, code: 8'h44};  // Left
      5'd23:   e = '{intro: 8'h5B, code: 8'h42};  // Down
      5'd24:   e = '{intro: 8'h5B, code: 8'h41};  // Up
      default: e = '{intro: 8'h00, code: 8'h00};  // PrintScreen, ScrollLock, Pause, unused
    endcase
    return e;
  endfunction

endpackage

@@ src/hkve_front.sv @@
// Front end: classifies a key item and builds its full byte sequence combinationally.
// Depends on hkve_pkg; feeds hkve_queue.
module hkve_front (
  input  logic          in_valid,
  input  logic [7:0]    usage,
  input  logic          shift,
  input  logic          alt,
  input  logic          ctrl_key,
  input  logic          gui,
  input  logic          q_full,
  output logic          in_ready,
  output logic          push,
  output hkve_pkg::seq_t seq
);
  import hkve_pkg::*;

  logic [7:0]       usage_off;
  logic             mapped;
  key_entry_t       ent;
  logic [4:0]       mod;
  logic             modified;
  logic [3:0]       mod_ones;
  logic [4:0]       num;
  logic [1:0]       num_tens;
  logic [4:0]       num_ones;
  logic [LEN_W-1:0] n;
  logic             emits;

  assign in_ready  = !q_full;
  assign usage_off = usage - KEY_FIRST;
  assign mapped    = (usage >= KEY_FIRST) && (usage <= KEY_LAST);
  assign ent       = key_lookup(usage_off[4:0]);

  // Modifier number 1..16 and its decimal digits
  assign mod      = {1'b0, gui, ctrl_key, alt, shift} + 5'd1;
  assign modified = shift | alt | ctrl_key | gui;
  assign mod_ones = (mod >= 5'd10) ? 4'(mod - 5'd10) : mod[3:0];

  // VT220 number (at most 24) split into tens and ones
  assign num = ent.code[4:0];
  always_comb begin
    if (num >= 5'd20) begin
      num_tens = 2'd2;
      num_ones = num - 5'd20;
    end else if (num >= 5'd10) begin
      num_tens = 2'd1;
      num_ones = num - 5'd10;
    end else begin
      num_tens = 2'd0;
      num_ones = num;
    end
  end

  // Assemble the sequence slot by slot
  always_comb begin
    seq.bytes = '0;
    n         = '0;
    emits     = 1'b0;
    if (ent.intro != 8'h00) begin
      emits = 1'b1;
      seq.bytes[n[SLOT_W-1:0]] = CH_ESC;
      n = n + 1'b1;
      if (!modified) begin
        seq.bytes[n[SLOT_W-1:0]] = ent.intro;
        n = n + 1'b1;
      end else begin
        seq.bytes[n[SLOT_W-1:0]] = CH_LBRACK;
        n = n + 1'b1;
        seq.bytes[n[SLOT_W-1:0]] = CH_ONE;
        n = n + 1'b1;
        seq.bytes[n[SLOT_W-1:0]] = CH_SEMI;
        n = n + 1'b1;
        if (mod >= 5'd10) begin
          seq.bytes[n[SLOT_W-1:0]] = CH_ONE;
          n = n + 1'b1;
        end
        seq.bytes[n[SLOT_W-1:0]] = CH_ZERO + {4'd0, mod_ones};
        n = n + 1'b1;
      end
      seq.bytes[n[SLOT_W-1:0]] = ent.code;
      n = n + 1'b1;
    end else if (ent.code != 8'h00) begin
      emits = 1'b1;
      seq.bytes[n[SLOT_W-1:0]] = CH_ESC;
      n = n + 1'b1;
      seq.bytes[n[SLOT_W-1:0]] = CH_LBRACK;
      n = n + 1'b1;
      if (num_tens != 2'd0) begin
        seq.bytes[n[SLOT_W-1:0]] = CH_ZERO + {6'd0, num_tens};
        n = n + 1'b1;
      end
      seq.bytes[n[SLOT_W-1:0]] = CH_ZERO + {3'd0, num_ones};
      n = n + 1'b1;
      if (modified) begin
        seq.bytes[n[SLOT_W-1:0]] = CH_SEMI;
        n = n + 1'b1;
        if (mod >= 5'd10) begin
          seq.bytes[n[SLOT_W-1:0]] = CH_ONE;
          n = n + 1'b1;
        end
        seq.bytes[n[SLOT_W-1:0]] = CH_ZERO + {4'd0, mod_ones};
        n = n + 1'b1;
      end
      seq.bytes[n[SLOT_W-1:0]] = CH_TILDE;
      n = n + 1'b1;
    end
    seq.len = n;
  end

  // Keys without a sequence are accepted and dropped here
  assign push = in_valid && in_ready && mapped && emits;

endmodule

@@ src/hkve_queue.sv @@
// Two-entry queue of encoded sequences between the front and back ends.
// Depends on hkve_pkg.
module hkve_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hkve_pkg::seq_t      wr_seq,
  input  logic                pop,
  output hkve_pkg::seq_t      head,
  output hkve_pkg::q_status_t status
);
  import hkve_pkg::*;

  seq_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_seq;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head         = slot[rd_ptr];
  assign status.empty = (count == 2'd0);
  assign status.full  = (count == 2'd2);

endmodule

@@ src/hkve_back.sv @@
// Back end: sends head bytes one per cycle through an output register unless stalled.
// Depends on hkve_pkg; reads from hkve_queue.
module hkve_back (
  input  logic                clk,
  input  logic                rst,
  input  hkve_pkg::seq_t      head,
  input  hkve_pkg::q_status_t status,
  output logic                pop,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [7:0]          byte_out,
  output logic                last
);
  import hkve_pkg::*;

  logic [SLOT_W-1:0] pos;
  logic              load;
  logic              take;
  logic              at_end;

  assign load   = !out_valid || out_ready;
  assign take   = load && !status.empty;
  assign at_end = ({1'b0, pos} + 1'b1) == head.len;
  assign pop    = take && at_end;

  // Control: output valid and byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (load) begin
        out_valid <= !status.empty;
      end
      if (take) begin
        pos <= at_end ? '0 : pos + 1'b1;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (take) begin
      byte_out <= head.bytes[pos];
      last     <= at_end;
    end
  end

endmodule

@@ src/hid_key_to_vt_escape_encoder_core.sv @@
// Top level of the HID key to VT escape-sequence encoder: front, queue and back end.
// Depends on hkve_pkg, hkve_front, hkve_queue and hkve_back.
//
// Channel   Dir  Payload (low bit first)
// s_axis    in   tdata: usage[7:0], shift, alt, ctrl_key, gui, zero pad
// m_axis    out  tdata: byte_out[7:0]; tlast: last
//
// A key item is taken whenever the two-entry queue has room.
// Each mapped key then leaves as 3 to 8 bytes, one per cycle while m_axis_tready
// is high, paced by the single output register; keys without a sequence produce nothing.
// Reset empties the queue and clears the output valid.
// A stalled output fills the queue, after which s_axis_tready drops.
module hid_key_to_vt_escape_encoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // usage[7:0], shift, alt, ctrl_key, gui, pad[15:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // byte_out[7:0]
  output logic        m_axis_tlast
);
  import hkve_pkg::*;

  logic      q_push;
  logic      q_pop;
  seq_t      q_wr;
  seq_t      q_head;
  q_status_t q_stat;

  // Classify and encode
  hkve_front u_front (
    .in_valid (s_axis_tvalid),
    .usage    (s_axis_tdata[7:0]),
    .shift    (s_axis_tdata[8]),
    .alt      (s_axis_tdata[9]),
    .ctrl_key (s_axis_tdata[10]),
    .gui      (s_axis_tdata[11]),
    .q_full   (q_stat.full),
    .in_ready (s_axis_tready),
    .push     (q_push),
    .seq      (q_wr)
  );

  // Sequence queue
  hkve_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_seq (q_wr),
    .pop    (q_pop),
    .head   (q_head),
    .status (q_stat)
  );

  // Byte sender
  hkve_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .status    (q_stat),
    .pop       (q_pop),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .byte_out  (m_axis_tdata),
    .last      (m_axis_tlast)
  );

  // Checks
  a_q_status: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_push_accepted: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (s_axis_tvalid && s_axis_tready && !q_stat.full))
    else $error("push without accepted item or into full queue");

  a_head_len: assert property (@(posedge clk) disable iff (rst)
    !q_stat.empty |-> (q_head.len >= 4'd3 && q_head.len <= 4'd8))
    else $error("queued sequence length out of range");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (m_axis_tvalid && m_axis_tlast))
    else $error("end of sequence not marked on output");

endmodule

@@ sim/tb_hid_key_to_vt_escape_encoder_core.sv @@
// Testbench for hid_key_to_vt_escape_encoder_core: directed key table, then random key events.
// Depends on hkve_pkg (character constants and key range) and the encoder RTL in src.
// Every accepted byte is checked against a directed golden string or an in-bench escape-sequence encoder.
module tb_hid_key_to_vt_escape_encoder_core;
  import hkve_pkg::*;

  localparam int STALL_LIMIT   = 2000;  // cycles with no item moving on either side
  localparam int RAND_KEYS     = 133;   // random key events, mapped or not
  localparam int DRAIN_CYCLES  = 20;
  localparam int REPORT_MAX    = 10;

  // Escape sequence as predicted: byte 0 goes out first
  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [3:0]      len;
  } vt_seq_t;

  // One row of the directed table; want is used only when typed is set
  typedef struct packed {
    logic [7:0] usage;
    logic [3:0] mods;     // shift, alt, ctrl_key, gui from bit 0 up
    logic       typed;
    vt_seq_t    want;
  } key_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // usage[7:0], shift, alt, ctrl_key, gui, pad[15:12]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // byte_out[7:0]
  logic        m_axis_tlast;

  vt_seq_t    seq_plan[$];   // sequence per key, in send order
  logic [8:0] byte_queue[$]; // {last, byte} still to come out
  key_row_t   dir_rows[$];

  int src_idle_pct = 35;
  int snk_idle_pct = 72;
  int mismatches   = 0;
  int stall_cycles = 0;
  int keys_sent    = 0;
  int keys_mapped  = 0;
  int bytes_seen   = 0;

  hid_key_to_vt_escape_encoder_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 20-unit clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- encoder model

  function automatic vt_seq_t append_byte(input vt_seq_t s, input logic [7:0] b);
    s.bytes[s.len[2:0]] = b;
    s.len = s.len + 4'd1;
    return s;
  endfunction

  // Decimal text, one or two digits
  function automatic vt_seq_t append_dec(input vt_seq_t s, input int v);
    logic [7:0] tens;
    logic [7:0] ones;
    tens = 8'(v / 10);
    ones = 8'(v % 10);
    if (v >= 10) s = append_byte(s, CH_ZERO + tens);
    return append_byte(s, CH_ZERO + ones);
  endfunction

  function automatic vt_seq_t seq_from_text(input string t);
    vt_seq_t s;
    s = '0;
    for (int i = 0; i < t.len(); i++) s = append_byte(s, t[i]);
    return s;
  endfunction

  // Escape sequence for one key event; empty for unmapped and blank keys
  function automatic vt_seq_t encode_key(input logic [7:0] usage, input logic [3:0] mods);
    vt_seq_t    s;
    logic [7:0] intro;
    logic [7:0] code;
    int         modn;
    s     = '0;
    intro = 8'h00;
    code  = 8'h00;
    modn  = int'(mods) + 1;
    // intro is nonzero for the cursor-style form, else code is the tilde number
    case (usage)
      8'h3A: begin intro = "O"; code = "P"; end   // F1
      8'h3B: begin intro = "O"; code = "Q"; end
      8'h3C: begin intro = "O"; code = "R"; end
      8'h3D: begin intro = "O"; code = "S"; end   // F4
      8'h3E: code = 8'd15;                        // F5
      8'h3F: code = 8'd17;
      8'h40: code = 8'd18;
      8'h41: code = 8'd19;
      8'h42: code = 8'd20;
      8'h43: code = 8'd21;
      8'h44: code = 8'd23;
      8'h45: code = 8'd24;                        // F12
      8'h49: code = 8'd2;                         // Insert
      8'h4A: begin intro = "["; code = "H"; end   // Home
      8'h4B: code = 8'd5;                         // PageUp
      8'h4C: code = 8'd3;                         // Delete
      8'h4D: begin intro = "["; code = "F"; end   // End
      8'h4E: code = 8'd6;                         // PageDown
      8'h4F: begin intro = "["; code = "C"; end   // Right
      8'h50: begin intro = "["; code = "D"; end
      8'h51: begin intro = "["; code = "B"; end
      8'h52: begin intro = "["; code = "A"; end   // Up
      default: ;                                  // blank keys and outside the range
    endcase
    if (intro != 8'h00) begin
      s = append_byte(s, CH_ESC);
      if (modn == 1) begin
        s = append_byte(s, intro);
      end else begin
        s = append_byte(s, CH_LBRACK);
        s = append_byte(s, CH_ONE);
        s = append_byte(s, CH_SEMI);
        s = append_dec(s, modn);
      end
      s = append_byte(s, code);
    end else if (code != 8'h00) begin
      s = append_byte(s, CH_ESC);
      s = append_byte(s, CH_LBRACK);
      s = append_dec(s, int'(code));
      if (modn != 1) begin
        s = append_byte(s, CH_SEMI);
        s = append_dec(s, modn);
      end
      s = append_byte(s, CH_TILDE);
    end
    return s;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic add_row(input logic [7:0] usage, input logic [3:0] mods,
                         input logic typed, input string golden);
    key_row_t r;
    r.usage = usage;
    r.mods  = mods;
    r.typed = typed;
    r.want  = seq_from_text(golden);
    dir_rows.push_back(r);
  endtask

  // Queue the key's sequence, then hold the item until it is taken
  task automatic send_key(input logic [7:0] usage, input logic [3:0] mods, input vt_seq_t seq);
    seq_plan.push_back(seq);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, mods, usage};
    do @(posedge clk); while (!s_axis_tready);
    keys_sent++;
    if (seq.len != 0) keys_mapped++;
  endtask

  // Receiver stalls at the rate of the current phase
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else     m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // ---------------------------------------------------------------- checking

  task automatic note_mismatch(input string what, input int want, input int got);
    if (mismatches < REPORT_MAX)
      $display("mismatch: %s expected 0x%02h got 0x%02h (byte %0d)", what, want, got, bytes_seen);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    vt_seq_t    cur;
    logic [8:0] want;
    if (!rst) begin
      // accepted key: its bytes join the expected stream
      if (s_axis_tvalid && s_axis_tready) begin
        cur = seq_plan.pop_front();
        for (int i = 0; i < int'(cur.len); i++)
          byte_queue.push_back({(i == int'(cur.len) - 1), cur.bytes[i]});
      end
      // accepted byte: compare field by field with the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        if (byte_queue.size() == 0) begin
          note_mismatch("unexpected byte, none pending:", 0, m_axis_tdata);
        end else begin
          want = byte_queue.pop_front();
          if (m_axis_tdata !== want[7:0]) note_mismatch("byte_out", want[7:0], m_axis_tdata);
          if (m_axis_tlast !== want[8])   note_mismatch("last", want[8], m_axis_tlast);
        end
        bytes_seen++;
      end
      // watchdog on lack of progress
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run
    logic [7:0] usage;
    logic [3:0] mods;
    vt_seq_t    seq;
    int         keys_rand;
    int         phase_goal;

    // directed table: range edges, each table form, blank keys, modifier extremes
    add_row(8'h00, 4'h0, 1'b1, "");
    add_row(8'hFF, 4'hF, 1'b1, "");
    add_row(8'h39, 4'h0, 1'b1, "");
    add_row(8'h53, 4'hF, 1'b1, "");
    add_row(8'hAA, 4'h5, 1'b1, "");
    add_row(8'h3A, 4'h0, 1'b1, "\033OP");
    add_row(8'h3A, 4'hF, 1'b1, "\033[1;16P");
    add_row(8'h3D, 4'h1, 1'b0, "");
    add_row(8'h3E, 4'h0, 1'b1, "\033[15~");
    add_row(8'h3E, 4'h1, 1'b0, "");
    add_row(8'h45, 4'hF, 1'b1, "\033[24;16~");
    add_row(8'h44, 4'h8, 1'b0, "");
    add_row(8'h46, 4'h0, 1'b1, "");
    add_row(8'h47, 4'h5, 1'b1, "");
    add_row(8'h48, 4'hF, 1'b1, "");
    add_row(8'h49, 4'h0, 1'b0, "");
    add_row(8'h49, 4'h9, 1'b0, "");
    add_row(8'h4A, 4'h0, 1'b1, "\033[H");
    add_row(8'h4A, 4'h2, 1'b0, "");
    add_row(8'h4B, 4'h4, 1'b0, "");
    add_row(8'h4C, 4'h3, 1'b0, "");
    add_row(8'h4D, 4'h6, 1'b0, "");
    add_row(8'h4E, 4'h7, 1'b0, "");
    add_row(8'h4F, 4'h0, 1'b0, "");
    add_row(8'h50, 4'hA, 1'b0, "");
    add_row(8'h51, 4'hC, 1'b0, "");
    add_row(8'h52, 4'hF, 1'b1, "\033[1;16A");

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      seq = dir_rows[i].typed ? dir_rows[i].want : encode_key(dir_rows[i].usage, dir_rows[i].mods);
      send_key(dir_rows[i].usage, dir_rows[i].mods, seq);
    end

    // random keys over three pacing phases, mapped and unmapped alike
    keys_rand = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 35; snk_idle_pct = 72; end
        1:       begin src_idle_pct = 72; snk_idle_pct = 35; end
        default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
      endcase
      phase_goal = (phase == 2) ? RAND_KEYS : (RAND_KEYS * (phase + 1)) / 3;
      while (keys_rand < phase_goal) begin
        if ($urandom_range(99) < 85) usage = 8'($urandom_range(KEY_LAST, KEY_FIRST));
        else                         usage = 8'($urandom_range(255, 0));
        mods = 4'($urandom_range(15, 0));
        seq  = encode_key(usage, mods);
        send_key(usage, mods, seq);
        keys_rand++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then watch a little longer for stray bytes
    while (seq_plan.size() != 0 || byte_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (byte_queue.size() != 0) begin
      $display("%0d expected bytes never arrived", byte_queue.size());
      mismatches++;
    end
    $display("covered %0d key events (%0d with a sequence), %0d output bytes checked",
             keys_sent, keys_mapped, bytes_seen);
    $display("paced with sender-heavy, receiver-heavy and free-running phases; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/hkve_pkg.sv
src/hkve_front.sv
src/hkve_queue.sv
src/hkve_back.sv
src/hid_key_to_vt_escape_encoder_core.sv
sim/tb_hid_key_to_vt_escape_encoder_core.sv
